>>> src/cwo_pkg.sv
package cwo_pkg;

    localparam int PHASE_WIDTH_DEF      = 23;
    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int SINE_INDEX_WIDTH_DEF = 8;

    localparam int WAVE_SELECT_W  = 6;
    localparam int PULSE_WIDTH_W  = 12;
    localparam int TABLE_INDEX_W  = 8;
    localparam int TABLE_VALUE_W  = 8;
    localparam int SAMPLE_FIELD_W = 17;
    localparam int OUT_TDATA_W    = ((SAMPLE_FIELD_W + 7) / 8) * 8;

    localparam int PULSE_SLICE_W = 17;
    localparam logic [PULSE_WIDTH_W-1:0] PULSE_FULL_CODE = 12'hFFF;

    localparam int LFSR_W       = 23;
    localparam int LFSR_METAL_W = 15;
    localparam logic [LFSR_W-1:0] LFSR_SEED = '1;
    localparam logic [LFSR_W-1:0] LFSR_LONG_TAPS =
        (LFSR_W'(1) << 22) | (LFSR_W'(1) << 17);
    localparam logic [LFSR_W-1:0] LFSR_METAL_TAPS =
        (LFSR_W'(1) << 14) | (LFSR_W'(1) << 8);
    localparam logic [LFSR_W-1:0] LFSR_METAL_MASK = LFSR_W'((1 << LFSR_METAL_W) - 1);

    localparam int SEL_NOISE = 0;
    localparam int SEL_METAL = 1;
    localparam int SEL_PULSE = 2;
    localparam int SEL_TRI   = 3;
    localparam int SEL_SAW   = 4;
    localparam int SEL_SINE  = 5;

    typedef enum logic [0:0] {
        OP_SAMPLE      = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } op_t;

endpackage

>>> src/cwo_ram.sv
module cwo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/cwo_wave.sv
module cwo_wave #(
    parameter int PHASE_WIDTH      = cwo_pkg::PHASE_WIDTH_DEF,
    parameter int SAMPLE_WIDTH     = cwo_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_INDEX_WIDTH = cwo_pkg::SINE_INDEX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  logic [PHASE_WIDTH-1:0]              phase,
    input  logic [PHASE_WIDTH-1:0]              previous_phase,
    input  logic [cwo_pkg::WAVE_SELECT_W-1:0]   wave_select,
    input  logic [cwo_pkg::PULSE_WIDTH_W-1:0]   pulse_width,
    input  logic [cwo_pkg::TABLE_VALUE_W-1:0]   sine_entry,
    output logic [cwo_pkg::SAMPLE_FIELD_W-1:0]  sample
);

    localparam int FW      = cwo_pkg::SAMPLE_FIELD_W;
    localparam int SIN_D   = SAMPLE_WIDTH - SINE_INDEX_WIDTH;
    localparam int SIN_SHL = (SIN_D > 0) ? SIN_D : 0;
    localparam int SIN_SHR = (SIN_D < 0) ? -SIN_D : 0;
    localparam int SAW_LSB = PHASE_WIDTH - SAMPLE_WIDTH - 1;
    localparam int TRI_LSB = PHASE_WIDTH - SAMPLE_WIDTH - 2;
    localparam int NCLK    = PHASE_WIDTH - 5;

    logic [cwo_pkg::LFSR_W-1:0] lfsr_reg;
    logic [cwo_pkg::LFSR_W-1:0] lfsr_next;
    logic [cwo_pkg::LFSR_W-1:0] lfsr_stepped;
    logic                       noise_on;
    logic [PHASE_WIDTH-1:0]     tri_src;
    logic [cwo_pkg::PULSE_WIDTH_W:0] pulse_thr;
    logic [FW-1:0]              w_noise;
    logic [FW-1:0]              w_pulse;
    logic [FW-1:0]              w_tri;
    logic [FW-1:0]              w_saw;
    logic [FW-1:0]              w_sine;
    logic [31:0]                sine_wide;

    assign noise_on = wave_select[cwo_pkg::SEL_NOISE] | wave_select[cwo_pkg::SEL_METAL];

    always_comb
    begin
        lfsr_stepped = lfsr_reg >> 1;
        if (wave_select[cwo_pkg::SEL_METAL])
        begin
            if (lfsr_reg[0])
            begin
                lfsr_stepped = lfsr_stepped ^ cwo_pkg::LFSR_METAL_TAPS;
            end
            lfsr_stepped = lfsr_stepped & cwo_pkg::LFSR_METAL_MASK;
        end
        else if (lfsr_reg[0])
        begin
            lfsr_stepped = lfsr_stepped ^ cwo_pkg::LFSR_LONG_TAPS;
        end

        lfsr_next = lfsr_reg;
        if (step_en && noise_on && (phase[NCLK] != previous_phase[NCLK]))
        begin
            lfsr_next = lfsr_stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= cwo_pkg::LFSR_SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // noise output reflects the step taken for this sample
    assign w_noise = FW'(lfsr_next[SAMPLE_WIDTH-1:0]);

    assign pulse_thr = (pulse_width == cwo_pkg::PULSE_FULL_CODE) ?
                       {1'b1, {cwo_pkg::PULSE_WIDTH_W{1'b0}}} : {1'b0, pulse_width};
    assign w_pulse = (phase[PHASE_WIDTH-1 -: cwo_pkg::PULSE_SLICE_W] >= {pulse_thr, 4'b0000}) ?
                     FW'({SAMPLE_WIDTH{1'b1}}) : '0;

    assign tri_src = phase[PHASE_WIDTH-1] ? ~phase : phase;
    assign w_tri   = FW'(tri_src[TRI_LSB +: SAMPLE_WIDTH + 1]);
    assign w_saw   = FW'(phase[SAW_LSB +: SAMPLE_WIDTH]);

    assign sine_wide = ((32'(sine_entry) << SIN_SHL) >> SIN_SHR);
    assign w_sine    = FW'(sine_wide[SAMPLE_WIDTH-1:0]);

    always_comb
    begin
        if (wave_select == '0)
        begin
            sample = FW'(1) << (SAMPLE_WIDTH - 1);
        end
        else
        begin
            sample = '1;
            if (noise_on)
            begin
                sample = sample & w_noise;
            end
            if (wave_select[cwo_pkg::SEL_PULSE])
            begin
                sample = sample & w_pulse;
            end
            if (wave_select[cwo_pkg::SEL_TRI])
            begin
                sample = sample & w_tri;
            end
            if (wave_select[cwo_pkg::SEL_SAW])
            begin
                sample = sample & w_saw;
            end
            if (wave_select[cwo_pkg::SEL_SINE])
            begin
                sample = sample & w_sine;
            end
        end
    end

endmodule

>>> src/combined_waveform_oscillator_core.sv
// Channel  Dir  Ports                      Payload
// s        in   s_tvalid s_tready s_tdata   operation, phase, previous_phase, wave_select,
//                                           pulse_width, table_index, table_value
// m        out  m_tvalid m_tready m_tdata   sample
//
// One item per cycle sustained while m accepts. A sample is registered in stage 1 with its
// sine RAM read and then in the output register. Table writes give no output.
// Reset: noise LFSR set to all ones, pipeline emptied; sine RAM is not cleared.
// With m stalled the output register and stage 1 hold; s_tready drops once both are full.
module combined_waveform_oscillator_core #(
    parameter int PHASE_WIDTH      = cwo_pkg::PHASE_WIDTH_DEF,
    parameter int SAMPLE_WIDTH     = cwo_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_INDEX_WIDTH = cwo_pkg::SINE_INDEX_WIDTH_DEF,
    localparam int IN_BITS    = 2 * PHASE_WIDTH + 1 + cwo_pkg::WAVE_SELECT_W
                                + cwo_pkg::PULSE_WIDTH_W + cwo_pkg::TABLE_INDEX_W
                                + cwo_pkg::TABLE_VALUE_W,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation, phase, previous_phase, wave_select, pulse_width, table_index, table_value
    input  logic [IN_TDATA_W-1:0]           s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sample
    output logic [cwo_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int PH_LSB   = 1;
    localparam int PREV_LSB = PH_LSB + PHASE_WIDTH;
    localparam int SEL_LSB  = PREV_LSB + PHASE_WIDTH;
    localparam int PW_LSB   = SEL_LSB + cwo_pkg::WAVE_SELECT_W;
    localparam int IDX_LSB  = PW_LSB + cwo_pkg::PULSE_WIDTH_W;
    localparam int VAL_LSB  = IDX_LSB + cwo_pkg::TABLE_INDEX_W;
    localparam int FW       = cwo_pkg::SAMPLE_FIELD_W;

    cwo_pkg::op_t                     in_op;
    logic                             accept;
    logic                             accept_sample;
    logic                             accept_write;
    logic                             out_free;
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [PHASE_WIDTH-1:0]           s1_phase_reg;
    logic [PHASE_WIDTH-1:0]           s1_prev_reg;
    logic [cwo_pkg::WAVE_SELECT_W-1:0] s1_sel_reg;
    logic [cwo_pkg::PULSE_WIDTH_W-1:0] s1_width_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [FW-1:0]                    out_sample_reg;
    logic [FW-1:0]                    wave_sample;
    logic [cwo_pkg::TABLE_VALUE_W-1:0] sine_entry;
    logic                             step_en;

    assign in_op         = cwo_pkg::op_t'(s_tdata[0]);
    assign out_free      = !out_valid_reg || m_tready;
    assign s_tready      = !s1_valid_reg || out_free;
    assign accept        = s_tvalid && s_tready;
    assign accept_sample = accept && (in_op == cwo_pkg::OP_SAMPLE);
    assign accept_write  = accept && (in_op == cwo_pkg::OP_TABLE_WRITE);
    assign step_en       = s1_valid_reg && out_free;

    cwo_ram #(
        .WIDTH(cwo_pkg::TABLE_VALUE_W),
        .DEPTH(1 << SINE_INDEX_WIDTH)
    ) u_sine_ram (
        .clk    (clk),
        .wr_en  (accept_write),
        .wr_addr(SINE_INDEX_WIDTH'(s_tdata[IDX_LSB +: cwo_pkg::TABLE_INDEX_W])),
        .wr_data(s_tdata[VAL_LSB +: cwo_pkg::TABLE_VALUE_W]),
        .rd_en  (accept_sample),
        .rd_addr(s_tdata[PH_LSB + PHASE_WIDTH - 1 -: SINE_INDEX_WIDTH]),
        .rd_data(sine_entry)
    );

    cwo_wave #(
        .PHASE_WIDTH     (PHASE_WIDTH),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .SINE_INDEX_WIDTH(SINE_INDEX_WIDTH)
    ) u_wave (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .phase         (s1_phase_reg),
        .previous_phase(s1_prev_reg),
        .wave_select   (s1_sel_reg),
        .pulse_width   (s1_width_reg),
        .sine_entry    (sine_entry),
        .sample        (wave_sample)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept_sample)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_sample)
        begin
            s1_phase_reg <= s_tdata[PH_LSB +: PHASE_WIDTH];
            s1_prev_reg  <= s_tdata[PREV_LSB +: PHASE_WIDTH];
            s1_sel_reg   <= s_tdata[SEL_LSB +: cwo_pkg::WAVE_SELECT_W];
            s1_width_reg <= s_tdata[PW_LSB +: cwo_pkg::PULSE_WIDTH_W];
        end
        if (step_en)
        begin
            out_sample_reg <= wave_sample;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cwo_pkg::OUT_TDATA_W - FW){1'b0}}, out_sample_reg};

endmodule

>>> src/cwo_checker.sv
module cwo_checker #(
    parameter int IN_TDATA_W = 88
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [IN_TDATA_W-1:0]           s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cwo_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int FW = cwo_pkg::SAMPLE_FIELD_W;

    logic sample_xfer;

    assign sample_xfer = s_tvalid && s_tready
                         && (cwo_pkg::op_t'(s_tdata[0]) == cwo_pkg::OP_SAMPLE);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transfer changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer ##1 (!m_tvalid || m_tready) |=> m_tvalid)
        else $error("sample not presented two cycles after transfer");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[cwo_pkg::OUT_TDATA_W-1:FW] == '0))
        else $error("output padding bits not zero");

endmodule

bind combined_waveform_oscillator_core cwo_checker #(
    .IN_TDATA_W(IN_TDATA_W)
) u_cwo_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> test/combined_waveform_oscillator_core_tb.sv
module combined_waveform_oscillator_core_tb;

    localparam int PHASE_W    = cwo_pkg::PHASE_WIDTH_DEF;
    localparam int SAMPLE_W   = cwo_pkg::SAMPLE_WIDTH_DEF;
    localparam int SINE_IDX_W = cwo_pkg::SINE_INDEX_WIDTH_DEF;
    localparam int SINE_DEPTH = 1 << SINE_IDX_W;
    localparam int SEL_W      = cwo_pkg::WAVE_SELECT_W;
    localparam int PW_W       = cwo_pkg::PULSE_WIDTH_W;
    localparam int IDX_W      = cwo_pkg::TABLE_INDEX_W;
    localparam int VAL_W      = cwo_pkg::TABLE_VALUE_W;
    localparam int FIELD_W    = cwo_pkg::SAMPLE_FIELD_W;
    localparam int IN_BITS    = 2 * PHASE_W + 1 + SEL_W + PW_W + IDX_W + VAL_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int STALL_MAX       = 10;
    localparam int LATENCY         = 4;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int ZERO_PLAN_STEPS = 32;
    localparam int ZERO_SEARCH_MAX = 100000;
    localparam int MISMATCH_PRINTS = 50;

    localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SAMPLE_W) - 1);
    localparam logic [31:0] TRI_MASK    = 32'((64'd1 << (SAMPLE_W + 1)) - 1);
    localparam logic [31:0] MIDSCALE    = 32'(64'd1 << (SAMPLE_W - 1));

    localparam logic [PHASE_W-1:0] NOISE_CLK_BIT = PHASE_W'(1) << (PHASE_W - 5);
    // low bits of a long-mode state from which one metallic step yields zero
    localparam logic [15:0] METAL_ZERO_LEAD = 16'h8201;

    localparam logic [SEL_W-1:0] WAVE_NONE  = '0;
    localparam logic [SEL_W-1:0] WAVE_NOISE = SEL_W'(1 << cwo_pkg::SEL_NOISE);
    localparam logic [SEL_W-1:0] WAVE_METAL = SEL_W'(1 << cwo_pkg::SEL_METAL);
    localparam logic [SEL_W-1:0] WAVE_PULSE = SEL_W'(1 << cwo_pkg::SEL_PULSE);
    localparam logic [SEL_W-1:0] WAVE_TRI   = SEL_W'(1 << cwo_pkg::SEL_TRI);
    localparam logic [SEL_W-1:0] WAVE_SAW   = SEL_W'(1 << cwo_pkg::SEL_SAW);
    localparam logic [SEL_W-1:0] WAVE_SINE  = SEL_W'(1 << cwo_pkg::SEL_SINE);
    localparam logic [SEL_W-1:0] WAVE_ALL   = '1;

    typedef struct {
        cwo_pkg::op_t       op;
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] prev_phase;
        logic [SEL_W-1:0]   wave_select;
        logic [PW_W-1:0]    pulse_width;
        logic [IDX_W-1:0]   table_index;
        logic [VAL_W-1:0]   table_value;
    } osc_item_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // operation, phase, previous_phase, wave_select, pulse_width, table_index, table_value
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // sample
    logic [cwo_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic [cwo_pkg::LFSR_W-1:0] noise_lfsr = cwo_pkg::LFSR_SEED;
    logic [VAL_W-1:0]           sine_mem [SINE_DEPTH];
    bit                         sine_written [SINE_DEPTH];
    logic [FIELD_W-1:0]         expected_samples [$];

    bit idle_on = 1'b1;
    int mismatch_count = 0;
    int results_seen = 0;
    int stall_mark = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    combined_waveform_oscillator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [cwo_pkg::LFSR_W-1:0] lfsr_advance(
        logic [cwo_pkg::LFSR_W-1:0] v, logic metal);
        logic [cwo_pkg::LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0])
            r ^= metal ? cwo_pkg::LFSR_METAL_TAPS : cwo_pkg::LFSR_LONG_TAPS;
        if (metal)
            r &= cwo_pkg::LFSR_METAL_MASK;
        return r;
    endfunction

    // AND of all selected waveforms, midscale if none; steps the noise register as a side effect
    function automatic logic [FIELD_W-1:0] oscillator_sample(osc_item_t it);
        logic [31:0] acc;
        logic [31:0] ph;
        logic [31:0] thr;
        logic [31:0] folded;
        if (it.wave_select == WAVE_NONE)
            return FIELD_W'(MIDSCALE);
        acc = '1;
        ph  = 32'(it.phase);
        if (it.wave_select[cwo_pkg::SEL_NOISE] || it.wave_select[cwo_pkg::SEL_METAL])
        begin
            if (it.phase[PHASE_W-5] != it.prev_phase[PHASE_W-5])
                noise_lfsr = lfsr_advance(noise_lfsr, it.wave_select[cwo_pkg::SEL_METAL]);
            acc &= 32'(noise_lfsr) & SAMPLE_MASK;
        end
        if (it.wave_select[cwo_pkg::SEL_PULSE])
        begin
            thr = (it.pulse_width == cwo_pkg::PULSE_FULL_CODE)
                  ? 32'(cwo_pkg::PULSE_FULL_CODE) + 32'd1 : 32'(it.pulse_width);
            acc &= ((ph >> (PHASE_W - cwo_pkg::PULSE_SLICE_W)) >= (thr << 4))
                   ? SAMPLE_MASK : 32'd0;
        end
        if (it.wave_select[cwo_pkg::SEL_TRI])
        begin
            folded = ph[PHASE_W-1] ? ~ph : ph;
            acc &= (folded >> (PHASE_W - SAMPLE_W - 2)) & TRI_MASK;
        end
        if (it.wave_select[cwo_pkg::SEL_SAW])
            acc &= (ph >> (PHASE_W - SAMPLE_W - 1)) & SAMPLE_MASK;
        if (it.wave_select[cwo_pkg::SEL_SINE])
            acc &= (32'(sine_mem[ph[PHASE_W-1 -: SINE_IDX_W]]) << (SAMPLE_W - SINE_IDX_W))
                   & SAMPLE_MASK;
        return acc[FIELD_W-1:0];
    endfunction

    function automatic osc_item_t sample_item(logic [PHASE_W-1:0] ph, logic [PHASE_W-1:0] prev,
                                              logic [SEL_W-1:0] sel,
                                              logic [PW_W-1:0] pw);
        osc_item_t it;
        it.op          = cwo_pkg::OP_SAMPLE;
        it.phase       = ph;
        it.prev_phase  = prev;
        it.wave_select = sel;
        it.pulse_width = pw;
        it.table_index = IDX_W'($urandom);
        it.table_value = VAL_W'($urandom);
        return it;
    endfunction

    function automatic osc_item_t write_item(logic [IDX_W-1:0] idx,
                                             logic [VAL_W-1:0] val);
        osc_item_t it;
        it.op          = cwo_pkg::OP_TABLE_WRITE;
        it.phase       = PHASE_W'($urandom);
        it.prev_phase  = PHASE_W'($urandom);
        it.wave_select = SEL_W'($urandom);
        it.pulse_width = PW_W'($urandom);
        it.table_index = idx;
        it.table_value = val;
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] want);
        if (mismatch_count < MISMATCH_PRINTS)
            $display("mismatch %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(osc_item_t it);
        int gap;
        // never read a sine entry that was not loaded
        if (it.op == cwo_pkg::OP_SAMPLE && it.wave_select[cwo_pkg::SEL_SINE]
            && !sine_written[it.phase[PHASE_W-1 -: SINE_IDX_W]])
            it.wave_select[cwo_pkg::SEL_SINE] = 1'b0;
        gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({it.table_value, it.table_index, it.pulse_width,
                                 it.wave_select, it.prev_phase, it.phase, it.op});
        do
            @(posedge clk);
        while (!s_tready);
        if (it.op == cwo_pkg::OP_TABLE_WRITE)
        begin
            sine_mem[it.table_index]     = it.table_value;
            sine_written[it.table_index] = 1'b1;
        end
        else
            expected_samples.push_back(oscillator_sample(it));
    endtask

    task automatic wait_for_samples();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic test_table_load();
        logic [VAL_W-1:0] val;
        idle_on = 1'b1;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            val = (i == 0) ? '0 : (i == SINE_DEPTH - 1) ? '1 : VAL_W'($urandom);
            send_item(write_item(IDX_W'(i), val));
        end
    endtask

    task automatic test_waveforms();
        idle_on = 1'b1;
        // empty mask: midscale, noise register untouched
        send_item(sample_item(PHASE_W'($urandom), PHASE_W'($urandom), WAVE_NONE,
                              PW_W'($urandom)));
        send_item(sample_item('0, '0, WAVE_SAW, '0));
        send_item(sample_item('1, '0, WAVE_SAW, '0));
        send_item(sample_item(23'h3FFFFF, '0, WAVE_TRI, '0));
        send_item(sample_item(23'h400000, '0, WAVE_TRI, '0));
        send_item(sample_item('1, '0, WAVE_TRI, '0));
        send_item(sample_item('0, '0, WAVE_SINE, '0));
        send_item(sample_item('1, '0, WAVE_SINE, '0));
        send_item(sample_item('0, '0, WAVE_PULSE, '0));
        // full width code compares as one past the top
        send_item(sample_item('1, '0, WAVE_PULSE, cwo_pkg::PULSE_FULL_CODE));
        send_item(sample_item(23'h3FFFFF, '0, WAVE_PULSE, cwo_pkg::PULSE_FULL_CODE));
        send_item(sample_item(23'h3FFFFF, '0, WAVE_PULSE, 12'hFFE));
        send_item(sample_item(23'h200000, '0, WAVE_PULSE, 12'h800));
        send_item(sample_item(23'h1FFFFF, '0, WAVE_PULSE, 12'h800));
        send_item(sample_item('1, '0, WAVE_ALL, '0));
        wait_for_samples();
    endtask

    task automatic test_noise();
        idle_on = 1'b1;
        send_item(sample_item(NOISE_CLK_BIT, '0, WAVE_NOISE, '0));
        send_item(sample_item('0, '0, WAVE_NOISE, '0));
        // clock toggles but noise is off: no step
        send_item(sample_item(NOISE_CLK_BIT, '0, WAVE_SAW, '0));
        send_item(sample_item('0, '0, WAVE_NOISE, '0));
        send_item(sample_item('0, NOISE_CLK_BIT, WAVE_NOISE | WAVE_METAL, '0));
        send_item(sample_item(NOISE_CLK_BIT, '0, WAVE_METAL, '0));
        send_item(sample_item(NOISE_CLK_BIT, '0, WAVE_NOISE, '0));
        send_item(sample_item('1, ~NOISE_CLK_BIT, WAVE_ALL, '0));
        wait_for_samples();
    endtask

    task automatic test_write_readback();
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        idle_on = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            idx = IDX_W'($urandom);
            val = VAL_W'($urandom);
            send_item(write_item(idx, val));
            send_item(sample_item({idx, (PHASE_W - SINE_IDX_W)'($urandom)}, '0, WAVE_SINE, '0));
            send_item(write_item(idx, ~val));
            send_item(sample_item({idx, (PHASE_W - SINE_IDX_W)'($urandom)}, '0, WAVE_SINE, '0));
        end
        idle_on = 1'b1;
        wait_for_samples();
    endtask

    task automatic test_random();
        logic [PHASE_W-1:0] acc_phase;
        logic [PHASE_W-1:0] step;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] prev;
        logic [SEL_W-1:0]   sel;
        logic [PW_W-1:0]    pw;
        int pick;
        acc_phase = PHASE_W'($urandom);
        step      = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                idle_on = ((n / 150) % 3) != 2;
                step    = PHASE_W'($urandom_range(1, 1 << 20));
            end
            if (n == RANDOM_ITEMS / 2)
                wait_for_samples();
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(write_item(IDX_W'($urandom), VAL_W'($urandom)));
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    prev      = acc_phase;
                    acc_phase = acc_phase + step;
                    ph        = acc_phase;
                end
                else
                begin
                    ph   = PHASE_W'($urandom);
                    prev = (pick < 8) ? ph ^ NOISE_CLK_BIT : PHASE_W'($urandom);
                end
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    sel = WAVE_NONE;
                else if (pick < 45)
                    sel = SEL_W'(1 << $urandom_range(0, SEL_W - 1));
                else if (pick < 70)
                    sel = SEL_W'((1 << $urandom_range(0, SEL_W - 1))
                                 | (1 << $urandom_range(0, SEL_W - 1)));
                else
                    sel = SEL_W'($urandom_range(1, (1 << SEL_W) - 1));
                pick = $urandom_range(0, 9);
                pw = (pick == 0) ? '0 : (pick == 1) ? cwo_pkg::PULSE_FULL_CODE
                                                    : PW_W'($urandom);
                send_item(sample_item(ph, prev, sel, pw));
            end
        end
        idle_on = 1'b1;
        wait_for_samples();
    endtask

    // plan a short mix of long and metallic steps that ends in a state one metallic
    // step clears, drive it, then check that zero sticks
    task automatic test_noise_zero();
        logic [cwo_pkg::LFSR_W-1:0] trial;
        logic [ZERO_PLAN_STEPS-1:0] plan;
        logic [PHASE_W-1:0]         ph;
        int                         plan_len;
        int                         tries;
        idle_on  = 1'b0;
        plan     = '0;
        plan_len = 0;
        tries    = 0;
        while (plan_len == 0 && tries < ZERO_SEARCH_MAX)
        begin
            plan  = ZERO_PLAN_STEPS'($urandom);
            trial = noise_lfsr;
            for (int k = 0; k < ZERO_PLAN_STEPS; k++)
            begin
                if (plan_len == 0)
                begin
                    trial = lfsr_advance(trial, plan[k]);
                    if (trial[15:0] == METAL_ZERO_LEAD)
                        plan_len = k + 1;
                end
            end
            tries++;
        end
        for (int k = 0; k < plan_len; k++)
        begin
            ph = PHASE_W'($urandom);
            send_item(sample_item(ph, ph ^ NOISE_CLK_BIT, plan[k] ? WAVE_METAL : WAVE_NOISE,
                                  '0));
        end
        for (int k = 0; k < 6; k++)
        begin
            ph = PHASE_W'($urandom);
            send_item(sample_item(ph, ph ^ NOISE_CLK_BIT, (k % 2 == 0) ? WAVE_METAL : WAVE_NOISE,
                                  '0));
        end
        idle_on = 1'b1;
        wait_for_samples();
    endtask

    always @(negedge clk)
    begin
        if (results_seen != stall_mark)
        begin
            stall_mark = results_seen;
            stall_left = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        end
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_sample
        logic [FIELD_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_samples.size() == 0)
                report_mismatch("unexpected transfer", m_tdata[FIELD_W-1:0], '0);
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata[FIELD_W-1:0] !== want)
                    report_mismatch("sample", m_tdata[FIELD_W-1:0], want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** combined_waveform_oscillator_core: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_table_load();
        test_waveforms();
        test_noise();
        test_write_readback();
        test_random();
        test_noise_zero();
        wait_for_samples();
        if (mismatch_count == 0)
            $display("** combined_waveform_oscillator_core: PASSED **");
        else
            $display("** combined_waveform_oscillator_core: FAILED **");
        $finish;
    end

endmodule
